[hdl/rlt_pkg.sv]
package rlt_pkg;

   // channel format: Q8.8 by default
   localparam int CH_W    = 16;
   localparam int CH_FRAC = CH_W / 2;
   localparam int WT_W    = 16;

   // exposed channel: full product shifted down by the fraction bits
   localparam int EXP_W   = CH_W + CH_FRAC;
   // luma: weighted sum of three exposed channels, weight fraction dropped
   localparam int LSUM_W  = EXP_W + WT_W + 2;
   localparam int LUMA_W  = LSUM_W - WT_W;
   // denominator 1 + L in channel format
   localparam int DEN_W   = LUMA_W + 1;
   // white level squared and the quotient L * ONE * ONE / W^2
   localparam int WSQ_W   = 2 * CH_W;
   localparam int Q1_W    = LUMA_W + 2 * CH_FRAC;
   // scale factor k = ONE + quotient, split in two for the multipliers
   localparam int K_W     = Q1_W + 1;
   localparam int KL_W    = K_W / 2;
   localparam int KH_W    = K_W - KL_W;
   // full channel times k product
   localparam int P_W     = EXP_W + K_W;

   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_EXPOSURE_GAIN = 3'd0,
      CSR_WEIGHT_RED    = 3'd1,
      CSR_WEIGHT_GREEN  = 3'd2,
      CSR_WEIGHT_BLUE   = 3'd3,
      CSR_WHITE_LEVEL   = 3'd4,
      CSR_EXTENDED_MODE = 3'd5
   } csr_index_type;

   typedef logic [2:0][EXP_W-1:0] exp_pix_type;

endpackage

[hdl/rlt_div.sv]
// Pipelined restoring divider, one quotient bit per stage, shared divisor
// across lanes. Each lane starts from a partial remainder below the divisor.
module rlt_div #(
   parameter int LANES  = 3,
   parameter int DEN_W  = 27,
   parameter int Q_BITS = 16,
   parameter int SIDE_W = 3
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic [LANES-1:0][DEN_W-1:0]      in_rem,
   input  logic [LANES-1:0][Q_BITS-1:0]     in_num,
   input  logic [DEN_W-1:0]                 in_den,
   input  logic [SIDE_W-1:0]                in_side,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic [LANES-1:0][Q_BITS-1:0]     out_quo,
   output logic [SIDE_W-1:0]                out_side
);

   logic [Q_BITS-1:0]                            vld_ff;
   logic [Q_BITS-1:0][LANES-1:0][DEN_W-1:0]      rem_ff;
   logic [Q_BITS-1:0][LANES-1:0][Q_BITS-1:0]     num_ff;
   logic [Q_BITS-1:0][DEN_W-1:0]                 den_ff;
   logic [Q_BITS-1:0][SIDE_W-1:0]                side_ff;

   logic [Q_BITS:0]                              rdy;
   logic [Q_BITS-1:0]                            src_vld;
   logic [Q_BITS-1:0][LANES-1:0][DEN_W-1:0]      src_rem;
   logic [Q_BITS-1:0][LANES-1:0][Q_BITS-1:0]     src_num;
   logic [Q_BITS-1:0][DEN_W-1:0]                 src_den;
   logic [Q_BITS-1:0][SIDE_W-1:0]                src_side;
   logic [Q_BITS-1:0][LANES-1:0][DEN_W-1:0]      rem_in;
   logic [Q_BITS-1:0][LANES-1:0][Q_BITS-1:0]     num_in;

   // a stage takes a new item when empty or when its item moves on
   always_comb begin
      rdy[Q_BITS] = out_ready;
      for (int j = Q_BITS - 1; j >= 0; j--) begin
         rdy[j] = ~vld_ff[j] | rdy[j+1];
      end
   end

   // stage inputs
   always_comb begin
      src_vld[0]  = in_valid;
      src_rem[0]  = in_rem;
      src_num[0]  = in_num;
      src_den[0]  = in_den;
      src_side[0] = in_side;
      for (int j = 1; j < Q_BITS; j++) begin
         src_vld[j]  = vld_ff[j-1];
         src_rem[j]  = rem_ff[j-1];
         src_num[j]  = num_ff[j-1];
         src_den[j]  = den_ff[j-1];
         src_side[j] = side_ff[j-1];
      end
   end

   // one restoring step: shift in the next numerator bit, subtract if it fits;
   // quotient bits fill the numerator register from the bottom
   always_comb begin
      logic [DEN_W:0] t;
      for (int j = 0; j < Q_BITS; j++) begin
         for (int l = 0; l < LANES; l++) begin
            t = {src_rem[j][l], src_num[j][l][Q_BITS-1]};
            if (t >= {1'b0, src_den[j]}) begin
               rem_in[j][l] = DEN_W'(t - {1'b0, src_den[j]});
               num_in[j][l] = {src_num[j][l][Q_BITS-2:0], 1'b1};
            end else begin
               rem_in[j][l] = t[DEN_W-1:0];
               num_in[j][l] = {src_num[j][l][Q_BITS-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int j = 0; j < Q_BITS; j++) begin
            if (rdy[j]) vld_ff[j] <= src_vld[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < Q_BITS; j++) begin
         if (rdy[j] && src_vld[j]) begin
            rem_ff[j]  <= rem_in[j];
            num_ff[j]  <= num_in[j];
            den_ff[j]  <= src_den[j];
            side_ff[j] <= src_side[j];
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[Q_BITS-1];
   assign out_quo   = num_ff[Q_BITS-1];
   assign out_side  = side_ff[Q_BITS-1];

endmodule

[hdl/reinhard_luma_tone_mapper.sv]
// Channel  Direction  Handshake             Payload
// req      in         req_tvalid/tready     tdata: red_in, green_in, blue_in
// rsp      out        rsp_tvalid/tready     tdata: red_out, green_out, blue_out
//                                           tuser: clipped
// csr      in         csr_valid/csr_ready   csr_index, csr_data (always ready)
//
// One pixel per clock sustained while rsp_tready holds; pipeline: exposure, luma product and
// luma sum stages, 42 stages of the white-level quotient divider, three stages
// forming the channel products and saturation check, 16 stages of the output divider, output reg.
// Synchronous active-high reset clears all valid bits and loads register
// defaults. Each stage advances when empty or when the next one moves, so a
// stalled output lets upstream bubbles fill in.
module reinhard_luma_tone_mapper
   import rlt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [3*CH_W-1:0]     req_tdata,   // red_in, green_in, blue_in
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [3*CH_W-1:0]     rsp_tdata,   // red_out, green_out, blue_out
   output logic                  rsp_tuser,   // clipped
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CH_W-1:0]       csr_data
);

   localparam logic [K_W-1:0] K_ONE = K_W'(1) << CH_FRAC;

   // configuration
   logic [CH_W-1:0]  gain_ff;
   logic [2:0][WT_W-1:0] wt_ff;
   logic [CH_W-1:0]  white_ff;
   logic             ext_ff;
   logic [WSQ_W-1:0] wsq_ff;
   logic [CH_W-1:0]  white_safe;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff  <= CH_W'(256);
         wt_ff[0] <= WT_W'(13933);
         wt_ff[1] <= WT_W'(46871);
         wt_ff[2] <= WT_W'(4732);
         white_ff <= CH_W'(256);
         ext_ff   <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_EXPOSURE_GAIN: gain_ff  <= csr_data;
            CSR_WEIGHT_RED:    wt_ff[0] <= WT_W'(csr_data);
            CSR_WEIGHT_GREEN:  wt_ff[1] <= WT_W'(csr_data);
            CSR_WEIGHT_BLUE:   wt_ff[2] <= WT_W'(csr_data);
            CSR_WHITE_LEVEL:   white_ff <= csr_data;
            CSR_EXTENDED_MODE: ext_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   // white level squared, zero treated as one
   assign white_safe = (white_ff == '0) ? CH_W'(1) : white_ff;
   always_ff @(posedge clock) begin
      wsq_ff <= WSQ_W'(white_safe) * WSQ_W'(white_safe);
   end

   // handshake chain
   logic va_ff, vb_ff, vc_ff, ve_ff, vf_ff, vg_ff, vo_ff;
   logic rdy_a, rdy_b, rdy_c, rdy_e, rdy_f, rdy_g, rdy_o;
   logic d1_in_ready, d1_out_valid, d2_in_ready, d2_out_valid;

   assign rdy_o = ~vo_ff | rsp_tready;
   assign rdy_g = ~vg_ff | d2_in_ready;
   assign rdy_f = ~vf_ff | rdy_g;
   assign rdy_e = ~ve_ff | rdy_f;
   assign rdy_c = ~vc_ff | d1_in_ready;
   assign rdy_b = ~vb_ff | rdy_c;
   assign rdy_a = ~va_ff | rdy_b;
   assign req_tready = rdy_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         ve_ff <= 1'b0;
         vf_ff <= 1'b0;
         vg_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (rdy_a) va_ff <= req_tvalid;
         if (rdy_b) vb_ff <= va_ff;
         if (rdy_c) vc_ff <= vb_ff;
         if (rdy_e) ve_ff <= d1_out_valid;
         if (rdy_f) vf_ff <= ve_ff;
         if (rdy_g) vg_ff <= vf_ff;
         if (rdy_o) vo_ff <= d2_out_valid;
      end
   end

   // stage A: exposure
   exp_pix_type ea_ff, ea_in;
   always_comb begin
      logic [2*CH_W-1:0] prod;
      for (int c = 0; c < 3; c++) begin
         prod     = (2*CH_W)'(req_tdata[c*CH_W +: CH_W]) * (2*CH_W)'(gain_ff);
         ea_in[c] = prod[2*CH_W-1 -: EXP_W];
      end
   end
   always_ff @(posedge clock) begin
      if (rdy_a && req_tvalid) ea_ff <= ea_in;
   end

   // stage B: weighted channel products
   exp_pix_type eb_ff;
   logic [2:0][EXP_W+WT_W-1:0] pb_ff;
   always_ff @(posedge clock) begin
      if (rdy_b && va_ff) begin
         eb_ff <= ea_ff;
         for (int c = 0; c < 3; c++) begin
            pb_ff[c] <= (EXP_W+WT_W)'(ea_ff[c]) * (EXP_W+WT_W)'(wt_ff[c]);
         end
      end
   end

   // stage C: luma
   exp_pix_type ec_ff;
   logic [LUMA_W-1:0] lc_ff;
   logic [LSUM_W-1:0] lsum;
   assign lsum = LSUM_W'(pb_ff[0]) + LSUM_W'(pb_ff[1]) + LSUM_W'(pb_ff[2]);
   always_ff @(posedge clock) begin
      if (rdy_c && vb_ff) begin
         ec_ff <= eb_ff;
         lc_ff <= lsum[LSUM_W-1:WT_W];
      end
   end

   // quotient L * ONE * ONE / W^2 for the extended curve
   logic [0:0][WSQ_W-1:0] d1_rem;
   logic [0:0][Q1_W-1:0]  d1_num, d1_quo;
   logic [3*EXP_W+LUMA_W-1:0] d1_side_in, d1_side_out;
   assign d1_rem     = '0;
   assign d1_num[0]  = {lc_ff, (2*CH_FRAC)'(0)};
   assign d1_side_in = {ec_ff, lc_ff};

   rlt_div #(
      .LANES  (1),
      .DEN_W  (WSQ_W),
      .Q_BITS (Q1_W),
      .SIDE_W (3*EXP_W+LUMA_W)
   ) u_wdiv (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vc_ff),
      .in_ready  (d1_in_ready),
      .in_rem    (d1_rem),
      .in_num    (d1_num),
      .in_den    (wsq_ff),
      .in_side   (d1_side_in),
      .out_valid (d1_out_valid),
      .out_ready (rdy_e),
      .out_quo   (d1_quo),
      .out_side  (d1_side_out)
   );

   // stage E: k = ONE (+ quotient), split products e * k, denominator
   exp_pix_type        d1_e;
   logic [LUMA_W-1:0]  d1_l;
   logic [K_W-1:0]     k_e;
   logic [2:0][EXP_W+KL_W-1:0] plo_ff;
   logic [2:0][EXP_W+KH_W-1:0] phi_ff;
   logic [DEN_W-1:0]   den_e_ff;
   assign d1_l = d1_side_out[LUMA_W-1:0];
   assign d1_e = d1_side_out[LUMA_W +: 3*EXP_W];
   assign k_e  = ext_ff ? (K_ONE + K_W'(d1_quo[0])) : K_ONE;
   always_ff @(posedge clock) begin
      if (rdy_e && d1_out_valid) begin
         for (int c = 0; c < 3; c++) begin
            plo_ff[c] <= (EXP_W+KL_W)'(d1_e[c]) * (EXP_W+KL_W)'(k_e[KL_W-1:0]);
            phi_ff[c] <= (EXP_W+KH_W)'(d1_e[c]) * (EXP_W+KH_W)'(k_e[K_W-1:KL_W]);
         end
         den_e_ff <= DEN_W'(d1_l) + (DEN_W'(1) << CH_FRAC);
      end
   end

   // stage F: full products
   logic [2:0][P_W-1:0] pf_ff;
   logic [DEN_W-1:0]    den_f_ff;
   always_ff @(posedge clock) begin
      if (rdy_f && ve_ff) begin
         for (int c = 0; c < 3; c++) begin
            pf_ff[c] <= P_W'(plo_ff[c]) + (P_W'(phi_ff[c]) << KL_W);
         end
         den_f_ff <= den_e_ff;
      end
   end

   // stage G: saturation check, quotient would reach 2^CH_W
   logic [2:0]                 sat_ff;
   logic [2:0][DEN_W-1:0]      rem_g_ff;
   logic [2:0][CH_W-1:0]       num_g_ff;
   logic [DEN_W-1:0]           den_g_ff;
   always_ff @(posedge clock) begin
      if (rdy_g && vf_ff) begin
         for (int c = 0; c < 3; c++) begin
            sat_ff[c]   <= pf_ff[c][P_W-1:CH_W] >= (P_W-CH_W)'(den_f_ff);
            rem_g_ff[c] <= pf_ff[c][CH_W +: DEN_W];
            num_g_ff[c] <= pf_ff[c][CH_W-1:0];
         end
         den_g_ff <= den_f_ff;
      end
   end

   // output divide: e * k / (ONE + L)
   logic [2:0][CH_W-1:0] d2_quo;
   logic [2:0]           d2_sat;

   rlt_div #(
      .LANES  (3),
      .DEN_W  (DEN_W),
      .Q_BITS (CH_W),
      .SIDE_W (3)
   ) u_odiv (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vg_ff),
      .in_ready  (d2_in_ready),
      .in_rem    (rem_g_ff),
      .in_num    (num_g_ff),
      .in_den    (den_g_ff),
      .in_side   (sat_ff),
      .out_valid (d2_out_valid),
      .out_ready (rdy_o),
      .out_quo   (d2_quo),
      .out_side  (d2_sat)
   );

   // output register with saturation
   logic [3*CH_W-1:0] out_data_ff;
   logic              out_clip_ff;
   always_ff @(posedge clock) begin
      if (rdy_o && d2_out_valid) begin
         for (int c = 0; c < 3; c++) begin
            out_data_ff[c*CH_W +: CH_W] <= d2_sat[c] ? {CH_W{1'b1}} : d2_quo[c];
         end
         out_clip_ff <= |d2_sat;
      end
   end

   assign rsp_tvalid = vo_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_clip_ff;

endmodule

[dv/tone_map_checker.sv]
`timescale 1ns / 100ps

module tone_map_checker
   import rlt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [3*CH_W-1:0]     req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [3*CH_W-1:0]     rsp_tdata,
   input  logic                  rsp_tuser,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CH_W-1:0]       csr_data,
   output int                    fail_count,
   output int                    pending_pixels
);

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
      logic            clipped;
   } mapped_pixel_type;

   // register copy
   logic [CH_W-1:0] gain_q, white_q;
   logic [WT_W-1:0] wr_q, wg_q, wb_q;
   logic            ext_q;

   mapped_pixel_type mapped_queue[$];

   assign pending_pixels = mapped_queue.size();

   function automatic mapped_pixel_type tone_map(logic [3*CH_W-1:0] pix);
      logic [127:0] exposed [3];
      logic [127:0] luma, scale, den, wsq, q;
      logic [CH_W-1:0] chan;
      mapped_pixel_type res;
      res.clipped = 1'b0;
      for (int c = 0; c < 3; c++) begin
         chan = pix[c*CH_W +: CH_W];
         exposed[c] = (128'(chan) * 128'(gain_q)) >> CH_FRAC;
      end
      luma = (exposed[0] * wr_q + exposed[1] * wg_q + exposed[2] * wb_q) >> WT_W;
      if (luma != 0) begin
         scale = 128'(1) << CH_FRAC;
         if (ext_q) begin
            wsq = (white_q == 0) ? 128'(1) : 128'(white_q) * 128'(white_q);
            q = (luma << (2 * CH_FRAC)) / wsq;
            scale = scale + q;
         end
         den = (128'(1) << CH_FRAC) + luma;
         for (int c = 0; c < 3; c++)
            exposed[c] = (exposed[c] * scale) / den;
      end
      for (int c = 0; c < 3; c++) begin
         if (exposed[c] > 128'(16'hFFFF)) begin
            exposed[c] = 128'(16'hFFFF);
            res.clipped = 1'b1;
         end
      end
      res.red = exposed[0][CH_W-1:0];
      res.green = exposed[1][CH_W-1:0];
      res.blue = exposed[2][CH_W-1:0];
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [CH_W-1:0] got, logic [CH_W-1:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      mapped_pixel_type want;
      if (reset) begin
         gain_q <= 16'd256;
         wr_q <= 16'd13933;
         wg_q <= 16'd46871;
         wb_q <= 16'd4732;
         white_q <= 16'd256;
         ext_q <= 1'b0;
      end else begin
         // results first: an item accepted now never leaves in the same cycle
         if (rsp_tvalid && rsp_tready) begin
            if (mapped_queue.size() == 0) begin
               report_mismatch("unexpected item", rsp_tdata[CH_W-1:0], '0);
            end else begin
               want = mapped_queue.pop_front();
               if (rsp_tdata[0 +: CH_W] !== want.red)
                  report_mismatch("red", rsp_tdata[0 +: CH_W], want.red);
               if (rsp_tdata[CH_W +: CH_W] !== want.green)
                  report_mismatch("green", rsp_tdata[CH_W +: CH_W], want.green);
               if (rsp_tdata[2*CH_W +: CH_W] !== want.blue)
                  report_mismatch("blue", rsp_tdata[2*CH_W +: CH_W], want.blue);
               if (rsp_tuser !== want.clipped)
                  report_mismatch("clipped", 16'(rsp_tuser), 16'(want.clipped));
            end
         end
         if (req_tvalid && req_tready)
            mapped_queue.push_back(tone_map(req_tdata));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_EXPOSURE_GAIN: gain_q <= csr_data;
               CSR_WEIGHT_RED:    wr_q <= csr_data;
               CSR_WEIGHT_GREEN:  wg_q <= csr_data;
               CSR_WEIGHT_BLUE:   wb_q <= csr_data;
               CSR_WHITE_LEVEL:   white_q <= csr_data;
               CSR_EXTENDED_MODE: ext_q <= csr_data[0];
               default: ;
            endcase
         end
      end
   end

endmodule

[dv/tb_reinhard_luma_tone_mapper.sv]
`timescale 1ns / 100ps

module tb_reinhard_luma_tone_mapper;
   import rlt_pkg::*;

   localparam int DRAIN_CYCLES = 80;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [3*CH_W-1:0]    req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [3*CH_W-1:0]    rsp_tdata;
   logic                 rsp_tuser;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CH_W-1:0]      csr_data = '0;
   int                   fail_count;
   int                   pending_pixels;
   logic                 hold_off = 1'b0;
   int                   burst_left = 0;

   always #5 clock = ~clock;

   reinhard_luma_tone_mapper DUT (.*);

   tone_map_checker checker_inst (.*);

   // receiver: own stall pattern, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_off)
         rsp_tready <= 1'b0;
      else
         case ($urandom_range(3))
            0: rsp_tready <= ($urandom_range(4) == 0);
            1: rsp_tready <= 1'b1;
            default: rsp_tready <= ($urandom_range(3) != 0);
         endcase
   end

   // one pixel, sent in bursts with random gaps; valid drops only for a gap
   task automatic send_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= {b, g, r};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic idle_sender();
      req_tvalid <= 1'b0;
      burst_left = 0;
   endtask

   task automatic drain_pipe();
      idle_sender();
      @(posedge clock);
      while (pending_pixels != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CH_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_regs(logic [CH_W-1:0] gain, logic [CH_W-1:0] wr, logic [CH_W-1:0] wg,
                           logic [CH_W-1:0] wb, logic [CH_W-1:0] white, logic ext);
      drain_pipe();
      write_reg(CSR_EXPOSURE_GAIN, gain);
      write_reg(CSR_WEIGHT_RED, wr);
      write_reg(CSR_WEIGHT_GREEN, wg);
      write_reg(CSR_WEIGHT_BLUE, wb);
      write_reg(CSR_WHITE_LEVEL, white);
      write_reg(CSR_EXTENDED_MODE, {15'd0, ext});
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [CH_W-1:0] rand_chan();
      case ($urandom_range(5))
         0: return 16'(0);
         1: return 16'hFFFF;
         2: return 16'($urandom_range(0, 511));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_pixels(int count);
      for (int i = 0; i < count; i++)
         send_pixel(rand_chan(), rand_chan(), rand_chan());
   endtask

   task automatic directed_pixels();
      send_pixel(16'h0000, 16'h0000, 16'h0000);
      send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_pixel(16'h0100, 16'h0100, 16'h0100);
      send_pixel(16'hFFFF, 16'h0000, 16'h0000);
      send_pixel(16'h0000, 16'hFFFF, 16'h0000);
      send_pixel(16'h0000, 16'h0000, 16'hFFFF);
      send_pixel(16'h0001, 16'h0000, 16'h0000);
      send_pixel(16'h0001, 16'h0001, 16'h0001);
      send_pixel(16'hAAAA, 16'h5555, 16'hAAAA);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // defaults, plain form
      directed_pixels();
      random_pixels(150);

      // extended form, white level at 1.0
      set_regs(16'd256, 16'd13933, 16'd46871, 16'd4732, 16'd256, 1'b1);
      directed_pixels();
      random_pixels(150);

      // gain and weights at zero: zero luma passes exposed channels through
      set_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 1'b1);
      directed_pixels();
      set_regs(16'd512, 16'd0, 16'd0, 16'd0, 16'd1, 1'b0);
      random_pixels(60);

      // maximum gain and weights, smallest white level
      set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1, 1'b1);
      directed_pixels();
      random_pixels(100);

      // zero white level is treated as one
      set_regs(16'd300, 16'd20000, 16'd30000, 16'd15000, 16'd0, 1'b1);
      random_pixels(60);

      // large white level, with a long receiver hold-off
      set_regs(16'd64, 16'd13933, 16'd46871, 16'd4732, 16'hFFFF, 1'b1);
      fork
         begin
            hold_off = 1'b1;
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end
         random_pixels(150);
      join

      // random register settings
      for (int p = 0; p < 7; p++) begin
         set_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 1'($urandom));
         random_pixels(50);
      end

      drain_pipe();
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #2ms;
      $display("status: fail");
      $finish;
   end

endmodule

[reinhard_luma_tone_mapper.f]
hdl/rlt_pkg.sv
hdl/rlt_div.sv
hdl/reinhard_luma_tone_mapper.sv
dv/tone_map_checker.sv
dv/tb_reinhard_luma_tone_mapper.sv
